[rtl/pdcrc_pkg.sv]
// shared types, constants and crc helper for the packet deframer
`default_nettype none
package pdcrc_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 64;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 7;
	localparam int unsigned IDX_W  = 6;
	localparam int unsigned CNT_W  = 16;

	localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h43;
	localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h4B;
	localparam logic [BYTE_W-1:0] CRC_POLY        = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT        = 8'h00;

	// configuration register indexes
	localparam logic REG_SYNC_FIRST  = 1'b0;
	localparam logic REG_SYNC_SECOND = 1'b1;

	// result status codes
	localparam logic ST_GOOD    = 1'b0;
	localparam logic ST_CRC_ERR = 1'b1;

	typedef enum logic [8:0] {
		PH_SYNC1   = 9'b000000001,
		PH_SYNC2   = 9'b000000010,
		PH_TYPE    = 9'b000000100,
		PH_LEN_LO  = 9'b000001000,
		PH_LEN_HI  = 9'b000010000,
		PH_PAYLOAD = 9'b000100000,
		PH_CRC     = 9'b001000000,
		PH_DRN_RD  = 9'b010000000,
		PH_DRN_OUT = 9'b100000000
	} phase_t;

	// msb-first crc-8 over one byte
	function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = crc ^ b;
		for (int k = 0; k < BYTE_W; k++) begin
			if (v[BYTE_W-1]) begin
				v = {v[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[BYTE_W-2:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage
`default_nettype wire

[rtl/pdcrc_ram.sv]
// generic single-write, single-read ram with registered read
`default_nettype none
module pdcrc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/packet_deframer_crc8_check_core.sv]
// top level of the sync/type/length packet deframer with crc-8 check
// usage:
//   input channel carries one received byte per word (rx_byte, in_valid,
//   in_stall). output channel carries one result word per payload byte of
//   a good packet, or a single word for an empty good packet or a crc
//   mismatch (out_valid, out_stall). last_of_packet marks the final word.
//   sync_first / sync_second are written through cfg_we, cfg_index and
//   cfg_data while the block is idle.
// timing:
//   header, payload and crc bytes are taken one per cycle when not stalled.
//   a crc mismatch or an empty good packet shows its word the cycle after
//   the crc byte; a good packet drains from the payload ram (ram read, then
//   output load, per word) and the input stalls meanwhile
// reset:
//   arst_n clears the parser to hunting, the crc, counters and the output
//   valid; sync values go back to 'C' and 'K'. the payload ram is not
//   cleared: a packet only reads back bytes it wrote itself.
// back pressure:
//   the output word sits in a register; while it is held by out_stall the
//   crc byte and the drain wait, other bytes keep flowing in.
`default_nettype none
module packet_deframer_crc8_check_core #(
	parameter int unsigned MAX_PAYLOAD = pdcrc_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [pdcrc_pkg::BYTE_W-1:0] cfg_data,
	// input bytes
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [pdcrc_pkg::BYTE_W-1:0] rx_byte,
	// result words
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              status,
	output logic      [pdcrc_pkg::BYTE_W-1:0] packet_type,
	output logic      [pdcrc_pkg::LEN_W-1:0]  payload_length,
	output logic      [pdcrc_pkg::BYTE_W-1:0] payload_byte,
	output logic      [pdcrc_pkg::IDX_W-1:0]  byte_index,
	output logic                              last_of_packet,
	output logic      [pdcrc_pkg::CNT_W-1:0]  good_count,
	output logic      [pdcrc_pkg::CNT_W-1:0]  error_count
);
	import pdcrc_pkg::*;

	localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [2*BYTE_W-1:0] MAX_LEN = (2*BYTE_W)'(MAX_PAYLOAD);

	// configuration registers
	logic [BYTE_W-1:0] sync_first_q, sync_second_q;

	// parser state
	phase_t            phase_q;
	logic [BYTE_W-1:0] crc_q;
	logic [BYTE_W-1:0] type_q;
	logic [BYTE_W-1:0] len_lo_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  count_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  good_q, err_q;

	// output register
	logic              out_valid_q;
	logic              st_q;
	logic [BYTE_W-1:0] otype_q;
	logic [LEN_W-1:0]  olen_q;
	logic [BYTE_W-1:0] obyte_q;
	logic [IDX_W-1:0]  oidx_q;
	logic              olast_q;
	logic [CNT_W-1:0]  ogood_q, oerr_q;

	logic              in_acc;
	logic              out_free;
	logic [BYTE_W-1:0] crc_next;
	logic [2*BYTE_W-1:0] full_len;
	logic              ram_we, ram_re;
	logic [BYTE_W-1:0] ram_rdata;
	logic              drain_last;
	logic              crc_ok;
	logic              single_word;

	// output register can take a new word this cycle
	assign out_free = !out_valid_q || !out_stall;

	// stall while draining, and hold the crc byte until the output is free
	assign in_stall = (phase_q == PH_DRN_RD) || (phase_q == PH_DRN_OUT)
		|| ((phase_q == PH_CRC) && !out_free);
	assign in_acc   = in_valid && !in_stall;

	assign crc_next   = crc8_feed(crc_q, rx_byte);
	assign full_len   = {rx_byte, len_lo_q};
	assign drain_last = ({1'b0, idx_q} + LEN_W'(1)) == len_q;

	// crc byte that gives one word at once: a mismatch or an empty good packet
	assign crc_ok      = (rx_byte == crc_q);
	assign single_word = in_acc && (phase_q == PH_CRC) && (!crc_ok || (len_q == '0));

	assign ram_we = in_acc && (phase_q == PH_PAYLOAD);
	assign ram_re = (phase_q == PH_DRN_RD);

	pdcrc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_PAYLOAD)
	) u_payload_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (rx_byte),
		.re    (ram_re),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// parser and drain sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			crc_q    <= CRC_INIT;
			type_q   <= '0;
			len_lo_q <= '0;
			len_q    <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			good_q   <= '0;
			err_q    <= '0;
		end else begin
			case (phase_q)
				PH_SYNC1: begin
					if (in_acc && (rx_byte == sync_first_q)) begin
						crc_q   <= crc8_feed(CRC_INIT, rx_byte);
						phase_q <= PH_SYNC2;
					end
				end
				PH_SYNC2: begin
					// a wrong second sync is not retried as a first sync
					if (in_acc) begin
						if (rx_byte == sync_second_q) begin
							crc_q   <= crc_next;
							phase_q <= PH_TYPE;
						end else begin
							phase_q <= PH_SYNC1;
						end
					end
				end
				PH_TYPE: begin
					if (in_acc) begin
						type_q  <= rx_byte;
						crc_q   <= crc_next;
						phase_q <= PH_LEN_LO;
					end
				end
				PH_LEN_LO: begin
					if (in_acc) begin
						len_lo_q <= rx_byte;
						crc_q    <= crc_next;
						phase_q  <= PH_LEN_HI;
					end
				end
				PH_LEN_HI: begin
					if (in_acc) begin
						crc_q   <= crc_next;
						len_q   <= full_len[LEN_W-1:0];
						count_q <= '0;
						// oversize length drops the packet without a word
						if (full_len > MAX_LEN) begin
							phase_q <= PH_SYNC1;
						end else if (full_len == '0) begin
							phase_q <= PH_CRC;
						end else begin
							phase_q <= PH_PAYLOAD;
						end
					end
				end
				PH_PAYLOAD: begin
					if (in_acc) begin
						crc_q   <= crc_next;
						count_q <= count_q + LEN_W'(1);
						if ((count_q + LEN_W'(1)) >= len_q) begin
							phase_q <= PH_CRC;
						end
					end
				end
				PH_CRC: begin
					if (in_acc) begin
						idx_q <= '0;
						if (rx_byte == crc_q) begin
							good_q  <= good_q + CNT_W'(1);
							phase_q <= (len_q == '0) ? PH_SYNC1 : PH_DRN_RD;
						end else begin
							err_q   <= err_q + CNT_W'(1);
							phase_q <= PH_SYNC1;
						end
					end
				end
				PH_DRN_RD: begin
					phase_q <= PH_DRN_OUT;
				end
				PH_DRN_OUT: begin
					if (out_free) begin
						if (drain_last) begin
							phase_q <= PH_SYNC1;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							phase_q <= PH_DRN_RD;
						end
					end
				end
				default: begin
					phase_q <= PH_SYNC1;
				end
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (single_word || ((phase_q == PH_DRN_OUT) && out_free)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (single_word) begin
			// empty good packet or crc mismatch: single word
			otype_q <= type_q;
			olen_q  <= len_q;
			obyte_q <= '0;
			oidx_q  <= '0;
			olast_q <= 1'b1;
			if (crc_ok) begin
				st_q    <= ST_GOOD;
				ogood_q <= good_q + CNT_W'(1);
				oerr_q  <= err_q;
			end else begin
				st_q    <= ST_CRC_ERR;
				ogood_q <= good_q;
				oerr_q  <= err_q + CNT_W'(1);
			end
		end else if ((phase_q == PH_DRN_OUT) && out_free) begin
			st_q    <= ST_GOOD;
			otype_q <= type_q;
			olen_q  <= len_q;
			obyte_q <= ram_rdata;
			oidx_q  <= idx_q;
			olast_q <= drain_last;
			ogood_q <= good_q;
			oerr_q  <= err_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = st_q;
	assign packet_type    = otype_q;
	assign payload_length = olen_q;
	assign payload_byte   = obyte_q;
	assign byte_index     = oidx_q;
	assign last_of_packet = olast_q;
	assign good_count     = ogood_q;
	assign error_count    = oerr_q;

endmodule
`default_nettype wire

[dv/packet_deframer_crc8_check_core_tb.sv]
// self-checking testbench for the sync/type/length packet deframer with crc-8 check
`timescale 1ns / 100ps
module packet_deframer_crc8_check_core_tb;

	import pdcrc_pkg::*;

	localparam int MAX_LEN       = MAX_PAYLOAD_DEF;
	// long enough for a full-size good packet to drain, plus some slack
	localparam int SETTLE_CYCLES = 2 * MAX_LEN + 16;
	// long receiver hold-off, long enough to back the block up into its input
	localparam int HOLD_CYCLES   = 200;
	// cycles without any word moving before the run is declared hung
	localparam int QUIET_LIMIT   = 2000;
	// random input bytes per idling phase
	localparam int PHASE_BYTES   = 64;

	// one result word, laid out in port order so a concatenation fills it
	typedef struct packed {
		logic        status;
		logic [7:0]  packet_type;
		logic [6:0]  payload_length;
		logic [7:0]  payload_byte;
		logic [5:0]  byte_index;
		logic        last_of_packet;
		logic [15:0] good_count;
		logic [15:0] error_count;
	} result_word_t;

	// tracks the parser, its crc and counters, and the result words still due
	class expected_frames;
		logic [7:0]   sync_a;
		logic [7:0]   sync_b;
		phase_t       phase;
		logic [7:0]   crc;
		logic [7:0]   ptype;
		logic [15:0]  len;
		int           fill;
		logic [7:0]   held_bytes [MAX_LEN];
		logic [15:0]  good_total;
		logic [15:0]  bad_total;
		result_word_t due_words [$];
		int           mismatch_count;

		function new();
			sync_a         = SYNC_FIRST_RST;
			sync_b         = SYNC_SECOND_RST;
			phase          = PH_SYNC1;
			crc            = CRC_INIT;
			ptype          = '0;
			len            = '0;
			fill           = 0;
			good_total     = '0;
			bad_total      = '0;
			mismatch_count = 0;
		endfunction

		// one data bit at a time, msb first
		static function logic [7:0] crc_after(logic [7:0] c, logic [7:0] d);
			logic fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[7] ^ d[i];
				c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			end
			return c;
		endfunction

		function void set_sync(logic idx, logic [7:0] value);
			if (idx == REG_SYNC_FIRST) begin
				sync_a = value;
			end else begin
				sync_b = value;
			end
		endfunction

		function int waiting();
			return due_words.size();
		endfunction

		function void queue_word(logic st, logic [7:0] b, logic [5:0] idx, logic last);
			due_words.push_back({st, ptype, len[6:0], b, idx, last, good_total, bad_total});
		endfunction

		function void take_byte(logic [7:0] b);
			case (phase)
				PH_SYNC2: begin
					// a wrong second sync byte is not looked at again as a first one
					if (b == sync_b) begin
						crc   = crc_after(crc, b);
						phase = PH_TYPE;
					end else begin
						phase = PH_SYNC1;
					end
				end
				PH_TYPE: begin
					ptype = b;
					crc   = crc_after(crc, b);
					phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					len   = {8'h00, b};
					crc   = crc_after(crc, b);
					phase = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					len[15:8] = b;
					crc       = crc_after(crc, b);
					fill      = 0;
					if (len > MAX_LEN) begin
						phase = PH_SYNC1;
					end else if (len == 0) begin
						phase = PH_CRC;
					end else begin
						phase = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					held_bytes[fill] = b;
					fill++;
					crc = crc_after(crc, b);
					if (fill >= len) begin
						phase = PH_CRC;
					end
				end
				PH_CRC: begin
					if (b == crc) begin
						good_total++;
						if (len == 0) begin
							queue_word(ST_GOOD, 8'h00, 6'd0, 1'b1);
						end else begin
							for (int i = 0; i < len; i++) begin
								queue_word(ST_GOOD, held_bytes[i], 6'(i), i == len - 1);
							end
						end
					end else begin
						bad_total++;
						queue_word(ST_CRC_ERR, 8'h00, 6'd0, 1'b1);
					end
					phase = PH_SYNC1;
				end
				default: begin
					phase = PH_SYNC1;
					if (b == sync_a) begin
						crc   = crc_after(CRC_INIT, b);
						phase = PH_SYNC2;
					end
				end
			endcase
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_word(result_word_t got);
			result_word_t want;
			if (due_words.size() == 0) begin
				$error("result word %h arrived with nothing pending", got);
				mismatch_count++;
				return;
			end
			want = due_words.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("packet_type", want.packet_type, got.packet_type);
			compare_field("payload_length", want.payload_length, got.payload_length);
			compare_field("payload_byte", want.payload_byte, got.payload_byte);
			compare_field("byte_index", want.byte_index, got.byte_index);
			compare_field("last_of_packet", want.last_of_packet, got.last_of_packet);
			compare_field("good_count", want.good_count, got.good_count);
			compare_field("error_count", want.error_count, got.error_count);
		endfunction
	endclass

	// clock, reset and block inputs, all known from time zero
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = REG_SYNC_FIRST;
	logic [7:0]  cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic [7:0]  rx_byte   = '0;
	logic        out_stall = 1'b0;

	// block outputs
	logic        in_stall;
	logic        out_valid;
	logic        status;
	logic [7:0]  packet_type;
	logic [6:0]  payload_length;
	logic [7:0]  payload_byte;
	logic [5:0]  byte_index;
	logic        last_of_packet;
	logic [15:0] good_count;
	logic [15:0] error_count;

	// idling odds in percent, changed per phase
	int          send_idle_pct = 17;
	int          recv_idle_pct = 48;
	// asks the result side for one long hold-off
	logic        hold_pending  = 1'b0;
	int          bytes_sent    = 0;
	int          quiet_cycles  = 0;

	expected_frames frames;

	packet_deframer_crc8_check_core uut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: random stalls, or one long hold-off counted here
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				out_stall    <= 1'b1;
				hold_pending <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	// every result word taken is checked against the oldest one due
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			frames.check_word({status, packet_type, payload_length, payload_byte,
				byte_index, last_of_packet, good_count, error_count});
		end
	end

	// hang detection: restart the count whenever a word moves on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$error("no word moved for %0d cycles", QUIET_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	// offer one byte, idling first at random, and hold it until taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		frames.take_byte(b);
		bytes_sent++;
	endtask

	// sync, header, payload and crc; an oversize length stops after the header
	task automatic send_frame(input logic [7:0] ptype, input logic [15:0] len,
		input logic [7:0] crc_flip);
		logic [7:0] bytes_out [$];
		logic [7:0] crc;
		bytes_out = '{frames.sync_a, frames.sync_b, ptype, len[7:0], len[15:8]};
		if (len <= MAX_LEN) begin
			for (int i = 0; i < len; i++) begin
				bytes_out.push_back(8'($urandom_range(0, 255)));
			end
			crc = CRC_INIT;
			foreach (bytes_out[i]) begin
				crc = expected_frames::crc_after(crc, bytes_out[i]);
			end
			bytes_out.push_back(crc ^ crc_flip);
		end
		foreach (bytes_out[i]) begin
			send_byte(bytes_out[i]);
		end
	endtask

	// stop offering, let every due word arrive, then allow for a drain in flight
	task automatic settle();
		in_valid <= 1'b0;
		while (frames.waiting() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both sync registers, back to back, only while the block is idle
	task automatic write_syncs(input logic [7:0] first, input logic [7:0] second);
		cfg_we    <= 1'b1;
		cfg_index <= REG_SYNC_FIRST;
		cfg_data  <= first;
		@(posedge clk);
		frames.set_sync(REG_SYNC_FIRST, first);
		cfg_index <= REG_SYNC_SECOND;
		cfg_data  <= second;
		@(posedge clk);
		frames.set_sync(REG_SYNC_SECOND, second);
		cfg_we <= 1'b0;
	endtask

	// mostly well-formed packets with random content, plus broken ones and noise
	task automatic random_traffic(input int budget);
		int          start;
		int          pick;
		logic [15:0] len;
		logic [7:0]  b;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				// good packet, mostly short, now and then up to the maximum
				len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(9, MAX_LEN))
					: 16'($urandom_range(0, 8));
				send_frame(8'($urandom_range(0, 255)), len, 8'h00);
			end else if (pick < 74) begin
				// corrupted crc byte
				len = 16'($urandom_range(0, 8));
				send_frame(8'($urandom_range(0, 255)), len, 8'($urandom_range(1, 255)));
			end else if (pick < 84) begin
				// length above the maximum, packet dropped without a word
				len[15:8] = 8'($urandom_range(0, 255));
				len[7:0]  = (len[15:8] == 0) ? 8'($urandom_range(MAX_LEN + 1, 255))
					: 8'($urandom_range(0, 255));
				send_frame(8'($urandom_range(0, 255)), len, 8'h00);
			end else if (pick < 92) begin
				// first sync followed by a wrong second sync
				b = 8'($urandom_range(0, 255));
				if (b == frames.sync_b) begin
					b = ~b;
				end
				send_byte(frames.sync_a);
				send_byte(b);
			end else begin
				// line noise
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin : stimulus
		logic [7:0] sa;
		logic [7:0] sb;
		frames = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, on the reset sync values
		// empty good packet with the top type value
		send_frame(8'hFF, 16'd0, 8'h00);
		// empty packet with every crc bit flipped
		send_frame(8'h00, 16'd0, 8'hFF);
		// first sync twice: the repeat is a wrong second sync, and the byte after
		// it is hunted for a first sync again, not taken as a second one
		send_byte(frames.sync_a);
		send_byte(frames.sync_a);
		send_byte(frames.sync_b);
		// one above the maximum length, then a length set only in the high byte
		send_frame(8'h5A, 16'(MAX_LEN + 1), 8'h00);
		send_frame(8'hA5, 16'hFF00, 8'h00);
		settle();

		// sender idles less than the receiver, sync values at the extremes
		write_syncs(8'h00, 8'hFF);
		random_traffic(PHASE_BYTES);
		settle();

		// receiver idles less than the sender
		send_idle_pct = 48;
		recv_idle_pct = 17;
		write_syncs(8'hFF, 8'h00);
		random_traffic(PHASE_BYTES);
		settle();

		// no idling; random sync values, equal half the time
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sa = 8'($urandom_range(0, 255));
		sb = ($urandom_range(0, 1) == 1) ? sa : 8'($urandom_range(0, 255));
		write_syncs(sa, sb);
		// long hold-off while a full-size packet and a few more keep coming
		hold_pending <= 1'b1;
		send_frame(8'($urandom_range(0, 255)), 16'(MAX_LEN), 8'h00);
		repeat (3) send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 4)), 8'h00);
		random_traffic(PHASE_BYTES);
		settle();

		if (frames.mismatch_count == 0 && frames.waiting() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
